[sv/swm_pkg.sv]
`default_nettype none

package swm_pkg;

   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int WINDOW_BITS     = 7;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd3;

   // operation applied by every cell of the chain together
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_CLEAR,
      CMD_AGE,
      CMD_INSERT,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         del_en;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AGE,
      ST_INSERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

[sv/sliding_window_median.sv]
// An item is taken in ST_IDLE and steps through ST_AGE and ST_INSERT; once fill reaches the
// effective window it goes on through ST_SCAN and ST_EMIT, and ST_EMIT registers its result.
// No new item is taken until the block is back in ST_IDLE, and ST_EMIT waits while an earlier
// result is not yet taken; the median pick is one full rotation of the sorted cell chain past its head cell.
// Reset (synchronous): window empties, fill and ring position go to zero, window_size = 3.
`default_nettype none

module sliding_window_median #(
   parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                        clock,
   input  wire                                        reset,
   input  wire                                        req_tvalid,
   output logic                                       req_tready,
   input  wire [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]    req_tdata,  // sample
   input  wire                                        req_tuser,  // restart
   output logic                                       rsp_tvalid,
   input  wire                                        rsp_tready,
   output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0]   rsp_tdata,  // median_doubled
   input  wire                                        csr_we,
   input  wire [swm_pkg::WINDOW_BITS-1:0]             csr_wdata
);

   import swm_pkg::*;

   localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FW  = $clog2(MAX_WINDOW + 1);
   localparam int CW  = (FW > WINDOW_BITS) ? FW : WINDOW_BITS;
   localparam int ODW = ((SAMPLE_BITS + 8) / 8) * 8;

   state_type                     state_ff, state_in;
   logic [WINDOW_BITS-1:0]        window_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          restart_ff, restart_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [AW-1:0]                 scan_ff, scan_in;
   logic [FW-1:0]                 cnt_ff, cnt_in;
   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS:0]          rsp_data_ff, rsp_data_in;

   logic [CW-1:0]                 win_ext;
   logic [FW-1:0]                 weff, k1, k2;
   logic [AW-1:0]                 wp_base;
   logic                          ram_we;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic                          eligible;
   cell_ctl_type                  ctl;

   logic                          cell_valid [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_value [MAX_WINDOW];
   logic [AW-1:0]                 cell_age   [MAX_WINDOW];
   logic                          cell_ge    [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]         valid_vec;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ODW'(rsp_data_ff);

   // effective window: zero counts as one, clipped at the chain length
   assign win_ext = CW'(window_ff);
   always_comb begin
      if (win_ext == '0) begin
         weff = FW'(1);
      end else if (win_ext > CW'(MAX_WINDOW)) begin
         weff = FW'(MAX_WINDOW);
      end else begin
         weff = FW'(win_ext);
      end
   end
   assign k1 = (weff - FW'(1)) >> 1;
   assign k2 = weff >> 1;

   assign wp_base  = restart_ff ? '0 : wp_ff;
   assign ram_we   = (state_ff == ST_AGE);
   assign eligible = cell_valid[0] && (FW'(cell_age[0]) < weff);

   // ring keeps arrival order; slot at wp holds the oldest sample once full
   swm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_base),
      .wr_data (sample_ff),
      .rd_addr (wp_ff),
      .rd_data (ram_rdata)
   );

   genvar gi;
   generate
      for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
         logic                          p_valid, n_valid, p_ge;
         logic signed [SAMPLE_BITS-1:0] p_value, n_value;
         logic [AW-1:0]                 p_age, n_age;
         if (gi == 0) begin : g_first
            assign p_valid = 1'b0;
            assign p_value = '0;
            assign p_age   = '0;
            assign p_ge    = 1'b0;
         end else begin : g_mid
            assign p_valid = cell_valid[gi-1];
            assign p_value = cell_value[gi-1];
            assign p_age   = cell_age[gi-1];
            assign p_ge    = cell_ge[gi-1];
         end
         if (gi == MAX_WINDOW - 1) begin : g_wrap
            assign n_valid = cell_valid[0];
            assign n_value = cell_value[0];
            assign n_age   = cell_age[0];
         end else begin : g_next
            assign n_valid = cell_valid[gi+1];
            assign n_value = cell_value[gi+1];
            assign n_age   = cell_age[gi+1];
         end
         swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .MAX_WINDOW  (MAX_WINDOW),
            .LAST_CELL   (gi == MAX_WINDOW - 1)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_value  (sample_ff),
            .old_value  ($signed(ram_rdata)),
            .prev_valid (p_valid),
            .prev_value (p_value),
            .prev_age   (p_age),
            .prev_ge    (p_ge),
            .next_valid (n_valid),
            .next_value (n_value),
            .next_age   (n_age),
            .valid      (cell_valid[gi]),
            .value      (cell_value[gi]),
            .age        (cell_age[gi]),
            .ge         (cell_ge[gi])
         );
         assign valid_vec[gi] = cell_valid[gi];
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      restart_in   = restart_ff;
      fill_in      = fill_ff;
      wp_in        = wp_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ctl.cmd      = CMD_HOLD;
      ctl.del_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in  = $signed(req_tdata[SAMPLE_BITS-1:0]);
               restart_in = req_tuser;
               state_in   = ST_AGE;
            end
         end
         ST_AGE: begin
            // clear the chain on restart; else drop the oldest when the chain is full, age the rest
            ctl.cmd    = restart_ff ? CMD_CLEAR : CMD_AGE;
            ctl.del_en = (fill_ff == FW'(MAX_WINDOW));
            wp_in      = (wp_base == AW'(MAX_WINDOW - 1)) ? '0 : wp_base + AW'(1);
            if (restart_ff) begin
               fill_in = FW'(1);
            end else if (fill_ff < FW'(MAX_WINDOW)) begin
               fill_in = fill_ff + FW'(1);
            end
            state_in   = ST_INSERT;
         end
         ST_INSERT: begin
            ctl.cmd = CMD_INSERT;
            scan_in = '0;
            cnt_in  = '0;
            if (fill_ff >= weff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // head cell sees the sorted chain in ascending order over one turn
            ctl.cmd = CMD_ROTATE;
            if (eligible) begin
               if (cnt_ff == k1) begin
                  lo_in = cell_value[0];
               end
               if (cnt_ff == k2) begin
                  hi_in = cell_value[0];
               end
               cnt_in = cnt_ff + FW'(1);
            end
            scan_in = scan_ff + AW'(1);
            if (scan_ff == AW'(MAX_WINDOW - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {lo_ff[SAMPLE_BITS-1], lo_ff} + {hi_ff[SAMPLE_BITS-1], hi_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         fill_ff      <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
      end
      sample_ff   <= sample_in;
      restart_ff  <= restart_in;
      scan_ff     <= scan_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_data_ff <= rsp_data_in;
   end

   // while idle, the number of valid cells always equals the fill count
   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == int'(fill_ff)))
      else $error("cell valid count differs from fill count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_WINDOW))
      else $error("fill count beyond chain length");

   a_insert_fills_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> cell_valid[0])
      else $error("head cell empty after insert");

   a_scan_ends_in_emit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (scan_ff == AW'(MAX_WINDOW - 1))) |=> (state_ff == ST_EMIT))
      else $error("scan did not finish after one turn");

endmodule

`default_nettype wire

[sv/swm_ram.sv]
`default_nettype none

module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire                                      clock,
   input  wire                                      wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                          wr_data,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[sv/swm_cell.sv]
`default_nettype none

module swm_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int MAX_WINDOW  = 64,
   parameter bit LAST_CELL   = 1'b0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire swm_pkg::cell_ctl_type           ctl,
   input  wire signed [SAMPLE_BITS-1:0]         new_value,
   input  wire signed [SAMPLE_BITS-1:0]         old_value,
   input  wire                                  prev_valid,
   input  wire signed [SAMPLE_BITS-1:0]         prev_value,
   input  wire [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] prev_age,
   input  wire                                  prev_ge,
   input  wire                                  next_valid,
   input  wire signed [SAMPLE_BITS-1:0]         next_value,
   input  wire [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] next_age,
   output logic                                 valid,
   output logic signed [SAMPLE_BITS-1:0]        value,
   output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] age,
   output logic                                 ge
);

   import swm_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [AW-1:0] OLDEST_AGE = AW'(MAX_WINDOW - 1);

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]                 age_ff, age_in;
   logic                          after;

   // chain is ordered by (value, age); the new item sorts ahead of equal values
   assign ge    = !valid_ff || (value_ff >= new_value);
   assign after = valid_ff && ((value_ff > old_value) ||
                               ((value_ff == old_value) && (age_ff == OLDEST_AGE)));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      age_in   = age_ff;
      unique case (ctl.cmd)
         CMD_CLEAR: begin
            valid_in = 1'b0;
         end
         CMD_AGE: begin
            if (ctl.del_en && after) begin
               valid_in = LAST_CELL ? 1'b0 : next_valid;
               value_in = next_value;
               age_in   = next_age + AW'(1);
            end else begin
               age_in   = age_ff + AW'(1);
            end
         end
         CMD_INSERT: begin
            if (prev_ge) begin
               valid_in = prev_valid;
               value_in = prev_value;
               age_in   = prev_age;
            end else if (ge) begin
               valid_in = 1'b1;
               value_in = new_value;
               age_in   = '0;
            end
         end
         CMD_ROTATE: begin
            valid_in = next_valid;
            value_in = next_value;
            age_in   = next_age;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      age_ff   <= age_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign age   = age_ff;

endmodule

`default_nettype wire
